@@ rtl/i2cee_pkg.sv @@
// types and constants for the i2c eeprom access sequencer
// no dependencies; imported by i2c_eeprom_access_sequencer and the testbench

package i2cee_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] mem_address;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic [1:0]  bus_event;
  } in_word_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       need_data;
    logic [1:0] status;
  } out_word_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_DEV,
    PH_AHI,
    PH_ALO,
    PH_DATA_WAIT,
    PH_DATA_SENT,
    PH_RESTART,
    PH_DEVR,
    PH_RECV
  } phase_t;

  localparam logic [1:0] KIND_WR   = 2'd0;
  localparam logic [1:0] KIND_RD   = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_EVT  = 2'd3;

  localparam logic [1:0] EV_START_DONE = 2'd0;
  localparam logic [1:0] EV_ACK        = 2'd1;
  localparam logic [1:0] EV_NACK       = 2'd2;
  localparam logic [1:0] EV_RX         = 2'd3;

  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_SEND      = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_RECV      = 3'd4;
  localparam logic [2:0] CMD_RECV_LAST = 3'd5;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic [7:0] DEV_WR_MASK = 8'hfe;
  localparam logic [7:0] DEV_RD_BIT  = 8'h01;

endpackage

@@ rtl/i2c_eeprom_access_sequencer.sv @@
// i2c eeprom access sequencer: random read and page write above a byte engine
// depends on i2cee_pkg for word types, phase enum and command codes
//
// channel | direction | handshake         | word
// in_     | input     | in_valid/in_stall | in_word_t: request, data byte or bus event
// out_    | output    | out_valid/out_stall | out_word_t: bus command and status
// cfg_    | input     | cfg_wr_en         | device address byte, no read-back
//
// each accepted word is decoded against the phase combinationally; its result, if any,
// sits in the output register from the next cycle on, one word per cycle while in_stall is low.
// synchronous active-low reset clears the phase, counters and output valid;
// device address byte resets to 0xa0.
// in_stall is high only while a result waits in the output register and out_stall is high.

module i2c_eeprom_access_sequencer
  import i2cee_pkg::*;
#(
  parameter int MAX_TRANSFER = 65535
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam logic [15:0] MaxCount = 16'(MAX_TRANSFER);

  phase_t      phase_r, phase_nxt;
  logic        is_read_r, is_read_nxt;
  logic [15:0] target_r, target_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic        in_acc;
  logic        res_fire;
  out_word_t   res;
  logic [15:0] count_sat;
  logic [15:0] left_dec;
  logic [7:0]  dev_wr;
  logic [7:0]  dev_rd;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign count_sat = (in_word.byte_count > MaxCount) ? MaxCount : in_word.byte_count;
  assign left_dec  = left_r - 16'd1;
  assign dev_wr    = dev_r & DEV_WR_MASK;
  assign dev_rd    = dev_wr | DEV_RD_BIT;
  assign dev_nxt   = cfg_wr_en ? cfg_wr_data : dev_r;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    is_read_nxt = is_read_r;
    target_nxt  = target_r;
    left_nxt    = left_r;
    if (in_acc) begin
      unique case (in_word.kind) inside
        KIND_WR, KIND_RD: begin
          if (phase_r == PH_IDLE &&
              !(in_word.kind == KIND_RD && count_sat == 16'd0)) begin
            is_read_nxt = in_word.kind[0];
            target_nxt  = in_word.mem_address;
            left_nxt    = count_sat;
            phase_nxt   = PH_START;
          end
        end
        KIND_DATA: begin
          if (phase_r == PH_DATA_WAIT) begin
            left_nxt  = left_dec;
            phase_nxt = PH_DATA_SENT;
          end
        end
        default: begin
          unique case (in_word.bus_event)
            EV_START_DONE: begin
              if (phase_r == PH_START) phase_nxt = PH_DEV;
              else if (phase_r == PH_RESTART) phase_nxt = PH_DEVR;
            end
            EV_ACK: begin
              unique case (phase_r) inside
                PH_DEV: phase_nxt = PH_AHI;
                PH_AHI: phase_nxt = PH_ALO;
                PH_ALO, PH_DATA_SENT: begin
                  if (is_read_r) phase_nxt = PH_RESTART;
                  else if (left_r == 16'd0) phase_nxt = PH_IDLE;
                  else phase_nxt = PH_DATA_WAIT;
                end
                PH_DEVR: phase_nxt = PH_RECV;
                default: ;
              endcase
            end
            EV_NACK: begin
              unique case (phase_r) inside
                PH_DEV, PH_AHI, PH_ALO, PH_DATA_SENT, PH_DEVR: phase_nxt = PH_IDLE;
                default: ;
              endcase
            end
            default: begin
              if (phase_r == PH_RECV) begin
                left_nxt = left_dec;
                if (left_dec == 16'd0) phase_nxt = PH_IDLE;
              end
            end
          endcase
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res_fire = 1'b0;
    res      = '0;
    unique case (in_word.kind) inside
      KIND_WR, KIND_RD: begin
        if (phase_r == PH_IDLE) begin
          res_fire = 1'b1;
          if (in_word.kind == KIND_RD && count_sat == 16'd0) res.status = ST_DONE;
          else res.command = CMD_START;
        end
      end
      KIND_DATA: begin
        if (phase_r == PH_DATA_WAIT) begin
          res_fire    = 1'b1;
          res.command = CMD_SEND;
          res.tx_byte = in_word.data_byte;
        end
      end
      default: begin
        unique case (in_word.bus_event)
          EV_START_DONE: begin
            if (phase_r == PH_START || phase_r == PH_RESTART) begin
              res_fire    = 1'b1;
              res.command = CMD_SEND;
              res.tx_byte = (phase_r == PH_START) ? dev_wr : dev_rd;
            end
          end
          EV_ACK: begin
            unique case (phase_r) inside
              PH_DEV: begin
                res_fire    = 1'b1;
                res.command = CMD_SEND;
                res.tx_byte = target_r[15:8];
              end
              PH_AHI: begin
                res_fire    = 1'b1;
                res.command = CMD_SEND;
                res.tx_byte = target_r[7:0];
              end
              PH_ALO, PH_DATA_SENT: begin
                res_fire = 1'b1;
                if (is_read_r) begin
                  res.command = CMD_START;
                end else if (left_r == 16'd0) begin
                  res.command = CMD_STOP;
                  res.status  = ST_DONE;
                end else begin
                  res.need_data = 1'b1;
                end
              end
              PH_DEVR: begin
                res_fire    = 1'b1;
                res.command = (left_r <= 16'd1) ? CMD_RECV_LAST : CMD_RECV;
              end
              default: ;
            endcase
          end
          EV_NACK: begin
            unique case (phase_r) inside
              PH_DEV, PH_AHI, PH_ALO, PH_DATA_SENT, PH_DEVR: begin
                res_fire    = 1'b1;
                res.command = CMD_STOP;
                // nack on the last data byte still completes
                res.status  = (phase_r == PH_DATA_SENT && left_r == 16'd0) ?
                              ST_DONE : ST_FAIL;
              end
              default: ;
            endcase
          end
          default: begin
            if (phase_r == PH_RECV) begin
              res_fire     = 1'b1;
              res.rx_valid = 1'b1;
              res.rx_byte  = in_word.data_byte;
              if (left_dec == 16'd0) res.status = ST_DONE;
              else res.command = (left_dec == 16'd1) ? CMD_RECV_LAST : CMD_RECV;
            end
          end
        endcase
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_word_nxt  = out_word_r;
    if (in_acc) begin
      out_valid_nxt = res_fire;
      out_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_read_r   <= 1'b0;
      target_r    <= '0;
      left_r      <= '0;
      dev_r       <= 8'd160;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      is_read_r   <= is_read_nxt;
      target_r    <= target_nxt;
      left_r      <= left_nxt;
      dev_r       <= dev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_fire && res.status != ST_BUSY) |=> (phase_r == PH_IDLE))
    else $error("sequencer not idle after final status");

  a_recv_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RECV || phase_r == PH_RESTART || phase_r == PH_DEVR) |-> is_read_r)
    else $error("read phase reached by a write");

  a_wait_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA_WAIT) |-> (!is_read_r && left_r != 16'd0))
    else $error("data wanted with nothing left to write");

  a_recv_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RECV) |-> (left_r != 16'd0))
    else $error("receiving with zero bytes left");

  a_begin_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_IDLE && in_word.kind == KIND_WR) |=> (phase_r == PH_START))
    else $error("write request did not start");

endmodule

@@ sim/testbench.sv @@
// testbench for i2c_eeprom_access_sequencer: directed table then random bus transactions
// checks every result word against its own prediction; depends on i2cee_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import i2cee_pkg::*;

  localparam int MAX_XFER = 65535;
  localparam logic [7:0] DEV_RESET = 8'd160;
  localparam int LONG_HOLD = 120;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 420;
  localparam int PHASES = 4;

  typedef struct {
    in_word_t  w;
    bit        pinned;
    bit        has_res;
    out_word_t res;
  } stim_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  phase_t      seq_phase;
  bit          seq_is_read;
  logic [15:0] seq_addr;
  logic [15:0] seq_left;
  logic [7:0]  dev_byte;

  out_word_t awaited[$];
  stim_row_t plan[$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;

  i2c_eeprom_access_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t mk_in(logic [1:0] k, logic [15:0] a, logic [15:0] n,
                                     logic [7:0] d, logic [1:0] e);
    in_word_t w;
    w.kind = k;
    w.mem_address = a;
    w.byte_count = n;
    w.data_byte = d;
    w.bus_event = e;
    return w;
  endfunction

  function automatic out_word_t mk_out(logic [2:0] c, logic [7:0] tx, logic rxv,
                                       logic [7:0] rx, logic need, logic [1:0] st);
    out_word_t r;
    r.command = c;
    r.tx_byte = tx;
    r.rx_valid = rxv;
    r.rx_byte = rx;
    r.need_data = need;
    r.status = st;
    return r;
  endfunction

  // advances the shadow sequencer by one word; returns 1 when a result word follows
  function automatic bit next_bus_command(input in_word_t w, output out_word_t r);
    logic [7:0] dev_w;
    logic [7:0] dev_r;
    int count;
    dev_w = dev_byte & DEV_WR_MASK;
    dev_r = dev_w | DEV_RD_BIT;
    r = '0;
    r.status = ST_BUSY;
    case (w.kind)
      KIND_WR, KIND_RD: begin
        if (seq_phase != PH_IDLE) return 1'b0;
        count = int'(w.byte_count);
        if (count > MAX_XFER) count = MAX_XFER;
        if (w.kind == KIND_RD && count == 0) begin
          r.status = ST_DONE;
          return 1'b1;
        end
        seq_is_read = (w.kind == KIND_RD);
        seq_addr = w.mem_address;
        seq_left = count[15:0];
        seq_phase = PH_START;
        r.command = CMD_START;
      end
      KIND_DATA: begin
        if (seq_phase != PH_DATA_WAIT) return 1'b0;
        seq_left = seq_left - 16'd1;
        seq_phase = PH_DATA_SENT;
        r.command = CMD_SEND;
        r.tx_byte = w.data_byte;
      end
      default: begin
        case (w.bus_event)
          EV_START_DONE: begin
            if (seq_phase == PH_START) begin
              seq_phase = PH_DEV;
              r.command = CMD_SEND;
              r.tx_byte = dev_w;
            end else if (seq_phase == PH_RESTART) begin
              seq_phase = PH_DEVR;
              r.command = CMD_SEND;
              r.tx_byte = dev_r;
            end else begin
              return 1'b0;
            end
          end
          EV_ACK: begin
            case (seq_phase)
              PH_DEV: begin
                seq_phase = PH_AHI;
                r.command = CMD_SEND;
                r.tx_byte = seq_addr[15:8];
              end
              PH_AHI: begin
                seq_phase = PH_ALO;
                r.command = CMD_SEND;
                r.tx_byte = seq_addr[7:0];
              end
              PH_ALO, PH_DATA_SENT: begin
                if (seq_is_read) begin
                  seq_phase = PH_RESTART;
                  r.command = CMD_START;
                end else if (seq_left == 16'd0) begin
                  seq_phase = PH_IDLE;
                  r.command = CMD_STOP;
                  r.status = ST_DONE;
                end else begin
                  seq_phase = PH_DATA_WAIT;
                  r.need_data = 1'b1;
                end
              end
              PH_DEVR: begin
                seq_phase = PH_RECV;
                r.command = (seq_left <= 16'd1) ? CMD_RECV_LAST : CMD_RECV;
              end
              default: return 1'b0;
            endcase
          end
          EV_NACK: begin
            if (seq_phase == PH_DATA_SENT && seq_left == 16'd0) begin
              r.status = ST_DONE;
            end else if (seq_phase inside {PH_DEV, PH_AHI, PH_ALO, PH_DATA_SENT, PH_DEVR}) begin
              r.status = ST_FAIL;
            end else begin
              return 1'b0;
            end
            seq_phase = PH_IDLE;
            r.command = CMD_STOP;
          end
          default: begin
            if (seq_phase != PH_RECV) return 1'b0;
            seq_left = seq_left - 16'd1;
            r.rx_valid = 1'b1;
            r.rx_byte = w.data_byte;
            if (seq_left == 16'd0) begin
              seq_phase = PH_IDLE;
              r.status = ST_DONE;
            end else begin
              r.command = (seq_left == 16'd1) ? CMD_RECV_LAST : CMD_RECV;
            end
          end
        endcase
      end
    endcase
    return 1'b1;
  endfunction

  // mostly well-formed transactions with random content, some noise
  function automatic in_word_t pick_word();
    in_word_t w;
    int roll;
    w.kind = 2'($urandom_range(3));
    w.mem_address = 16'($urandom);
    w.byte_count = 16'($urandom);
    w.data_byte = 8'($urandom);
    w.bus_event = 2'($urandom_range(3));
    roll = $urandom_range(99);
    if (roll < 8) begin
      if (seq_phase == PH_IDLE && w.kind == KIND_RD) w.byte_count = 16'($urandom_range(6));
      return w;
    end
    roll = $urandom_range(99);
    w.kind = KIND_EVT;
    case (seq_phase)
      PH_IDLE: begin
        w.kind = $urandom_range(1) ? KIND_RD : KIND_WR;
        if (roll < 15) w.byte_count = 16'd0;
        else if (roll < 85) w.byte_count = 16'($urandom_range(1, 4));
        else if (roll < 93 || w.kind == KIND_RD) w.byte_count = 16'($urandom_range(5, 12));
      end
      PH_START, PH_RESTART: w.bus_event = (roll < 95) ? EV_START_DONE : EV_ACK;
      PH_DEV, PH_AHI, PH_ALO, PH_DEVR: w.bus_event = (roll < 94) ? EV_ACK : EV_NACK;
      PH_DATA_WAIT: w.kind = KIND_DATA;
      PH_DATA_SENT: begin
        if (seq_left == 16'd0) w.bus_event = (roll < 50) ? EV_ACK : EV_NACK;
        else if (seq_left > 16'd12) w.bus_event = (roll < 70) ? EV_ACK : EV_NACK;
        else w.bus_event = (roll < 94) ? EV_ACK : EV_NACK;
      end
      PH_RECV: w.bus_event = EV_RX;
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input out_word_t got,
                                 input out_word_t want);
    mismatches++;
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  task automatic add_free(input in_word_t w);
    plan.push_back('{w, 1'b0, 1'b0, '0});
  endtask

  task automatic add_pin(input in_word_t w, input bit has, input out_word_t res);
    plan.push_back('{w, 1'b1, has, res});
  endtask

  task automatic offer(input in_word_t w, output bit has, output out_word_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    burst_left--;
    has = next_bus_command(w, r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_dev_byte(input logic [7:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dev_byte = v;
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int seg;
    int mode;
    bit hold_served;
    hold_served = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(2);
        seg = $urandom_range(5, 40);
        repeat (seg) begin
          if (mode == 0) out_stall <= 1'b0;
          else if (mode == 1) out_stall <= ($urandom_range(99) < 30);
          else out_stall <= ($urandom_range(99) < 70);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        report_mismatch("result word with none expected", out_word, '0);
      end else begin
        want = awaited.pop_front();
        if (out_word !== want)
          report_mismatch("result word", out_word, want);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    bit has;
    out_word_t r;
    in_word_t w;
    int produced;
    logic [7:0] cfg_val;

    seq_phase = PH_IDLE;
    seq_is_read = 1'b0;
    seq_addr = '0;
    seq_left = '0;
    dev_byte = DEV_RESET;

    // full write of one byte at the top address, last byte nacked
    add_pin(mk_in(KIND_WR, 16'hffff, 16'd1, 8'h00, EV_START_DONE), 1'b1,
            mk_out(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, ST_BUSY));
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_START_DONE), 1'b1,
            mk_out(CMD_SEND, 8'ha0, 1'b0, 8'h00, 1'b0, ST_BUSY));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_free(mk_in(KIND_DATA, 16'h0000, 16'd0, 8'hff, EV_START_DONE));
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_NACK), 1'b1,
            mk_out(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ST_DONE));
    // zero-length read, then words that do not fit the idle phase
    add_pin(mk_in(KIND_RD, 16'h0000, 16'd0, 8'h00, EV_START_DONE), 1'b1,
            mk_out(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ST_DONE));
    add_pin(mk_in(KIND_DATA, 16'h0000, 16'd0, 8'h00, EV_START_DONE), 1'b0, '0);
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK), 1'b0, '0);
    // two-byte random read with a begin and a nack that must be ignored
    add_free(mk_in(KIND_RD, 16'h1234, 16'd2, 8'h00, EV_START_DONE));
    add_pin(mk_in(KIND_WR, 16'hffff, 16'hffff, 8'h00, EV_START_DONE), 1'b0, '0);
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_START_DONE));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_START_DONE), 1'b1,
            mk_out(CMD_SEND, 8'ha1, 1'b0, 8'h00, 1'b0, ST_BUSY));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_NACK), 1'b0, '0);
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_RX));
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'hff, EV_RX), 1'b1,
            mk_out(CMD_NONE, 8'h00, 1'b1, 8'hff, 1'b0, ST_DONE));
    // largest count, nacked on the device byte
    add_free(mk_in(KIND_WR, 16'h0000, 16'hffff, 8'h00, EV_START_DONE));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_START_DONE));
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_NACK), 1'b1,
            mk_out(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ST_FAIL));
    // zero-length write stops after the low address byte
    add_free(mk_in(KIND_WR, 16'h5a5a, 16'd0, 8'h00, EV_START_DONE));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_START_DONE));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_free(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK));
    add_pin(mk_in(KIND_EVT, 16'h0000, 16'd0, 8'h00, EV_ACK), 1'b1,
            mk_out(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ST_DONE));

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].w, has, r);
      if (plan[i].pinned) begin
        if (plan[i].has_res) awaited.push_back(plan[i].res);
      end else if (has) begin
        awaited.push_back(r);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cfg_val = 8'h00;
        1: cfg_val = 8'hfe;
        2: cfg_val = 8'h55;
        default: cfg_val = 8'($urandom_range(254));
      endcase
      write_dev_byte(cfg_val);
      if (p == 1) hold_req = 1'b1;
      produced = 0;
      while (produced < RANDOM_ITEMS / PHASES || seq_phase != PH_IDLE) begin
        w = pick_word();
        offer(w, has, r);
        produced++;
        if (has) awaited.push_back(r);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/i2cee_pkg.sv
rtl/i2c_eeprom_access_sequencer.sv
sim/testbench.sv
